FILE: rtl/core/ale_pkg.sv
// Package for the associated Legendre evaluator: constants, sequencer states and
// the control structs passed between the sequencer and the shared multiply unit.
// No dependencies.
package ale_pkg;

   // Degree limit and output format.
   localparam int unsigned MAX_DEGREE    = 8;
   localparam int unsigned OUT_FRAC_BITS = 24;

   // Field widths.
   localparam int unsigned DEG_W = 4;
   localparam int unsigned X_W   = 32;
   localparam int unsigned VAL_W = 64;
   localparam int unsigned FAC_W = 31;

   // Argument limits, +1.0 and -1.0 in Q1.30.
   localparam logic signed [X_W-1:0] X_PLUS_ONE  = 32'sd1073741824;
   localparam logic signed [X_W-1:0] X_MINUS_ONE = -32'sd1073741824;

   // Saturation limits of the result.
   localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

   // Seed start value, 1.0 with OUT_FRAC_BITS fraction bits.
   localparam logic signed [VAL_W-1:0] VAL_ONE = 64'sd1 <<< OUT_FRAC_BITS;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MWAIT,
      ST_SQ_INIT,
      ST_SQ,
      ST_SQ_RND,
      ST_SEED_A,
      ST_SEED_B,
      ST_SEED_C,
      ST_P1,
      ST_P1B,
      ST_P1C,
      ST_R_A,
      ST_R_B,
      ST_R_C,
      ST_R_D,
      ST_DIV,
      ST_R_E,
      ST_DONE
   } ale_state_type;

   // Phases of the shared multiply unit.
   typedef enum logic [1:0] {
      MP_IDLE,
      MP_LO,
      MP_HI,
      MP_FIN
   } mul_phase_type;

   // Command to the multiply unit.
   typedef struct packed {
      logic start;
      logic q30;
      logic fneg;
   } mul_ctl_type;

   // Status from the multiply unit.
   typedef struct packed {
      logic done;
      logic ovf;
   } mul_sts_type;

endpackage

FILE: rtl/core/ale_mul.sv
// Shared saturating multiply unit: a 64-bit signed value times a 31-bit factor,
// either exact (small integers) or scaled by 2^-30 with rounding. Uses ale_pkg.
module ale_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  ale_pkg::mul_ctl_type               ctl,
   input  logic signed [ale_pkg::VAL_W-1:0]   a,
   input  logic        [ale_pkg::FAC_W-1:0]   f,
   output ale_pkg::mul_sts_type               sts,
   output logic signed [ale_pkg::VAL_W-1:0]   res
);
   import ale_pkg::*;

   mul_phase_type            phase_ff, phase_in;
   logic [VAL_W-1:0]         ua_ff, ua_in;
   logic                     neg_ff, neg_in;
   logic                     q30_ff, q30_in;
   logic [FAC_W-1:0]         f_ff, f_in;
   logic [62:0]              plo_ff, plo_in;
   logic [62:0]              phi_ff, phi_in;
   logic signed [VAL_W-1:0]  res_ff, res_in;
   logic                     done_ff, done_in;
   logic                     ovf_ff, ovf_in;

   logic [31:0]              mop;
   logic [62:0]              prod;
   logic [95:0]              full;
   logic [95:0]              sum;
   logic [95:0]              mag;
   logic [VAL_W-1:0]         a_u;

   // One 32 by 31 multiplier, fed the low and then the high half of the magnitude.
   assign mop  = (phase_ff == MP_HI) ? ua_ff[63:32] : ua_ff[31:0];
   assign prod = {31'b0, mop} * {32'b0, f_ff};

   // Combine the partial products, round when scaling by 2^-30.
   assign full = (96'(phi_ff) << 32) + 96'(plo_ff);
   assign sum  = full + (q30_ff ? 96'h2000_0000 : 96'h0);
   assign mag  = q30_ff ? (sum >> 30) : sum;
   assign a_u  = a;

   always_comb begin
      phase_in = phase_ff;
      ua_in    = ua_ff;
      neg_in   = neg_ff;
      q30_in   = q30_ff;
      f_in     = f_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      ovf_in   = 1'b0;
      unique case (phase_ff)
         MP_IDLE: begin
            if (ctl.start) begin
               ua_in    = a_u[63] ? (~a_u + 64'd1) : a_u;
               neg_in   = a_u[63] ^ ctl.fneg;
               q30_in   = ctl.q30;
               f_in     = f;
               phase_in = MP_LO;
            end
         end
         MP_LO: begin
            plo_in   = prod;
            phase_in = MP_HI;
         end
         MP_HI: begin
            phi_in   = prod;
            phase_in = MP_FIN;
         end
         MP_FIN: begin
            // Saturate the signed result to the 64-bit range.
            done_in  = 1'b1;
            phase_in = MP_IDLE;
            if (neg_ff) begin
               if (mag > 96'h8000_0000_0000_0000) begin
                  res_in = VAL_MIN;
                  ovf_in = 1'b1;
               end else begin
                  res_in = ~mag[63:0] + 64'd1;
               end
            end else if (mag > 96'h7FFF_FFFF_FFFF_FFFF) begin
               res_in = VAL_MAX;
               ovf_in = 1'b1;
            end else begin
               res_in = mag[63:0];
            end
         end
         default: phase_in = MP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE;
         done_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
      end
      ua_ff  <= ua_in;
      neg_ff <= neg_in;
      q30_ff <= q30_in;
      f_ff   <= f_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      res_ff <= res_in;
   end

   assign sts.done = done_ff;
   assign sts.ovf  = ovf_ff;
   assign res      = res_ff;

endmodule

FILE: rtl/core/associated_legendre_eval_core.sv
// Top level of the associated Legendre evaluator: sequencer, square root,
// divider and result register around the shared multiply unit. Uses ale_pkg, ale_mul.
//
//  Channel | Direction | Word
//  req_    | in        | tdata: degree, order, x_value (Q1.30)
//  rsp_    | out       | tdata: value (Q.24); tuser: bad_args, overflow
//
// One word is worked at a time; req_tready is high only while the sequencer idles.
// Multiplies run on the shared unit, the square root is worked out bit by bit, and
// each recurrence step ends in a divide by k - m on the radix-2 divider.
// The result waits in an output register; a stalled rsp_ holds the sequencer in its
// final state. Reset is synchronous and clears the control state only.
module associated_legendre_eval_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [3:0] degree, [7:4] order, [39:8] x_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [1:0]  rsp_tuser    // [0] bad_args, [1] overflow
);
   import ale_pkg::*;

   ale_state_type           state_ff, state_in;
   ale_state_type           ret_ff, ret_in;
   logic [DEG_W-1:0]        deg_ff, deg_in;
   logic [DEG_W-1:0]        ord_ff, ord_in;
   logic signed [X_W-1:0]   x_ff, x_in;
   logic signed [VAL_W-1:0] pmm_ff, pmm_in;
   logic signed [VAL_W-1:0] pmmp1_ff, pmmp1_in;
   logic signed [VAL_W-1:0] t1_ff, t1_in;
   logic [FAC_W-1:0]        root_ff, root_in;
   logic [60:0]             sq_rem_ff, sq_rem_in;
   logic [61:0]             sq_r_ff, sq_r_in;
   logic [61:0]             sq_bit_ff, sq_bit_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [DEG_W-1:0]        idx_ff, idx_in;
   logic                    ovf_ff, ovf_in;
   logic [63:0]             dq_ff, dq_in;
   logic                    dneg_ff, dneg_in;
   logic [3:0]              drem_ff, drem_in;
   logic [3:0]              dd_ff, dd_in;
   logic signed [VAL_W-1:0] res_ff, res_in;
   logic                    bad_ff, bad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_bad_ff, rsp_bad_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   mul_ctl_type             mul_ctl;
   mul_sts_type             mul_sts;
   logic signed [VAL_W-1:0] mul_a;
   logic [FAC_W-1:0]        mul_f;
   logic signed [VAL_W-1:0] mul_res;

   logic                    args_bad;
   logic [FAC_W-1:0]        xmag;
   logic [61:0]             sq_trial;
   logic                    sq_ge;
   logic [4:0]              drem_sh;
   logic                    div_ge;
   logic signed [VAL_W-1:0] diff;
   logic                    diff_ovf;
   logic [64:0]             q_rnd;
   logic                    out_free;

   ale_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .f     (mul_f),
      .sts   (mul_sts),
      .res   (mul_res)
   );

   // Argument check and magnitude of x.
   assign args_bad = (ord_ff > deg_ff) || (32'(deg_ff) > MAX_DEGREE) ||
                     (x_ff > X_PLUS_ONE) || (x_ff < X_MINUS_ONE);
   assign xmag     = FAC_W'(x_ff[X_W-1] ? -x_ff : x_ff);

   // Square root step: trial subtract of the running root plus the current bit.
   assign sq_trial = sq_r_ff + sq_bit_ff;
   assign sq_ge    = {1'b0, sq_rem_ff} >= sq_trial;

   // Divider step: shift in the next dividend bit and try to subtract.
   assign drem_sh  = {drem_ff, dq_ff[63]};
   assign div_ge   = drem_sh >= {1'b0, dd_ff};

   // Saturating subtract of the two recurrence terms.
   assign diff     = t1_ff - mul_res;
   assign diff_ovf = (t1_ff[63] != mul_res[63]) && (diff[63] != t1_ff[63]);

   // Round the quotient to nearest, ties away from zero.
   assign q_rnd    = {1'b0, dq_ff} + ((drem_ff >= (dd_ff - drem_ff)) ? 65'd1 : 65'd0);

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (args_bad) begin
               state_in = ST_DONE;
            end else if (ord_ff != '0) begin
               state_in = ST_MWAIT;
            end else begin
               state_in = ST_P1;
            end
         end
         ST_MWAIT:   if (mul_sts.done) state_in = ret_ff;
         ST_SQ_INIT: state_in = ST_SQ;
         ST_SQ:      if (cnt_ff == '0) state_in = ST_SQ_RND;
         ST_SQ_RND:  state_in = ST_SEED_A;
         ST_SEED_A:  state_in = ST_MWAIT;
         ST_SEED_B:  state_in = ST_MWAIT;
         ST_SEED_C:  state_in = (idx_ff == ord_ff) ? ST_P1 : ST_SEED_A;
         ST_P1:      state_in = (deg_ff == ord_ff) ? ST_DONE : ST_MWAIT;
         ST_P1B:     state_in = ST_MWAIT;
         ST_P1C:     state_in = (deg_ff == ord_ff + 4'd1) ? ST_DONE : ST_R_A;
         ST_R_A:     state_in = ST_MWAIT;
         ST_R_B:     state_in = ST_MWAIT;
         ST_R_C:     state_in = ST_MWAIT;
         ST_R_D:     state_in = ST_DIV;
         ST_DIV:     if (cnt_ff == '0) state_in = ST_R_E;
         ST_R_E:     state_in = (idx_ff == deg_ff) ? ST_DONE : ST_R_A;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and multiply commands.
   always_comb begin
      ret_in       = ret_ff;
      deg_in       = deg_ff;
      ord_in       = ord_ff;
      x_in         = x_ff;
      pmm_in       = pmm_ff;
      pmmp1_in     = pmmp1_ff;
      t1_in        = t1_ff;
      root_in      = root_ff;
      sq_rem_in    = sq_rem_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      dq_in        = dq_ff;
      dneg_in      = dneg_ff;
      drem_in      = drem_ff;
      dd_in        = dd_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_ctl      = '0;
      mul_a        = pmm_ff;
      mul_f        = root_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               deg_in = req_tdata[3:0];
               ord_in = req_tdata[7:4];
               x_in   = req_tdata[39:8];
            end
         end
         ST_CHECK: begin
            ovf_in = 1'b0;
            bad_in = args_bad;
            res_in = '0;
            pmm_in = VAL_ONE;
            // x squared, exact, feeds the root of 1 - x^2.
            if (!args_bad && (ord_ff != '0)) begin
               mul_ctl.start = 1'b1;
               mul_a         = VAL_W'(xmag);
               mul_f         = xmag;
               ret_in        = ST_SQ_INIT;
            end
         end
         ST_MWAIT: begin
            if (mul_sts.done) ovf_in = ovf_ff | mul_sts.ovf;
         end
         ST_SQ_INIT: begin
            sq_rem_in = 61'h1000_0000_0000_0000 - mul_res[60:0];
            sq_r_in   = '0;
            sq_bit_in = 62'h1000_0000_0000_0000;
            cnt_in    = 6'd30;
         end
         ST_SQ: begin
            if (sq_ge) begin
               sq_rem_in = sq_rem_ff - sq_trial[60:0];
               sq_r_in   = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in   = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff - 6'd1;
         end
         ST_SQ_RND: begin
            root_in = FAC_W'(sq_r_ff) + ((62'(sq_rem_ff) > sq_r_ff) ? 31'd1 : 31'd0);
            idx_in  = 4'd1;
         end
         ST_SEED_A: begin
            mul_ctl.start = 1'b1;
            mul_ctl.q30   = 1'b1;
            mul_a         = pmm_ff;
            mul_f         = root_ff;
            ret_in        = ST_SEED_B;
         end
         ST_SEED_B: begin
            // Times the odd factor 2i-1.
            mul_ctl.start = 1'b1;
            mul_a         = mul_res;
            mul_f         = FAC_W'({idx_ff, 1'b0} - 5'd1);
            ret_in        = ST_SEED_C;
         end
         ST_SEED_C: begin
            // Condon-Shortley sign, saturating at the most negative value.
            if (mul_res == VAL_MIN) begin
               pmm_in = VAL_MAX;
               ovf_in = 1'b1;
            end else begin
               pmm_in = -mul_res;
            end
            idx_in = idx_ff + 4'd1;
         end
         ST_P1: begin
            if (deg_ff == ord_ff) begin
               res_in = pmm_ff;
            end else begin
               mul_ctl.start = 1'b1;
               mul_ctl.q30   = 1'b1;
               mul_ctl.fneg  = x_ff[X_W-1];
               mul_a         = pmm_ff;
               mul_f         = xmag;
               ret_in        = ST_P1B;
            end
         end
         ST_P1B: begin
            mul_ctl.start = 1'b1;
            mul_a         = mul_res;
            mul_f         = FAC_W'({ord_ff, 1'b1});
            ret_in        = ST_P1C;
         end
         ST_P1C: begin
            pmmp1_in = mul_res;
            res_in   = mul_res;
            idx_in   = ord_ff + 4'd2;
         end
         ST_R_A: begin
            mul_ctl.start = 1'b1;
            mul_ctl.q30   = 1'b1;
            mul_ctl.fneg  = x_ff[X_W-1];
            mul_a         = pmmp1_ff;
            mul_f         = xmag;
            ret_in        = ST_R_B;
         end
         ST_R_B: begin
            mul_ctl.start = 1'b1;
            mul_a         = mul_res;
            mul_f         = FAC_W'({idx_ff, 1'b0} - 5'd1);
            ret_in        = ST_R_C;
         end
         ST_R_C: begin
            t1_in         = mul_res;
            mul_ctl.start = 1'b1;
            mul_a         = pmm_ff;
            mul_f         = FAC_W'({1'b0, idx_ff} + {1'b0, ord_ff} - 5'd1);
            ret_in        = ST_R_D;
         end
         ST_R_D: begin
            // Difference of the terms, then set up the divide by k - m.
            if (diff_ovf) begin
               ovf_in  = 1'b1;
               dneg_in = t1_ff[63];
               dq_in   = t1_ff[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               dneg_in = diff[63];
               dq_in   = diff[63] ? (~diff + 64'd1) : diff;
            end
            drem_in = '0;
            dd_in   = idx_ff - ord_ff;
            cnt_in  = 6'd63;
         end
         ST_DIV: begin
            drem_in = div_ge ? 4'(drem_sh - {1'b0, dd_ff}) : drem_sh[3:0];
            dq_in   = {dq_ff[62:0], div_ge};
            cnt_in  = cnt_ff - 6'd1;
         end
         ST_R_E: begin
            pmm_in = pmmp1_ff;
            if (dneg_ff) begin
               if (q_rnd > 65'h0_8000_0000_0000_0000) begin
                  pmmp1_in = VAL_MIN;
                  res_in   = VAL_MIN;
                  ovf_in   = 1'b1;
               end else begin
                  pmmp1_in = ~q_rnd[63:0] + 64'd1;
                  res_in   = ~q_rnd[63:0] + 64'd1;
               end
            end else if (q_rnd > 65'h0_7FFF_FFFF_FFFF_FFFF) begin
               pmmp1_in = VAL_MAX;
               res_in   = VAL_MAX;
               ovf_in   = 1'b1;
            end else begin
               pmmp1_in = q_rnd[63:0];
               res_in   = q_rnd[63:0];
            end
            idx_in = idx_ff + 4'd1;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_bad_in   = bad_ff;
               rsp_ovf_in   = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      deg_ff       <= deg_in;
      ord_ff       <= ord_in;
      x_ff         <= x_in;
      pmm_ff       <= pmm_in;
      pmmp1_ff     <= pmmp1_in;
      t1_ff        <= t1_in;
      root_ff      <= root_in;
      sq_rem_ff    <= sq_rem_in;
      sq_r_ff      <= sq_r_in;
      sq_bit_ff    <= sq_bit_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      ovf_ff       <= ovf_in;
      dq_ff        <= dq_in;
      dneg_ff      <= dneg_in;
      drem_ff      <= drem_in;
      dd_ff        <= dd_in;
      res_ff       <= res_in;
      bad_ff       <= bad_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_bad_ff};

endmodule

FILE: tb/associated_legendre_eval_checker.sv
// Checker for the associated Legendre evaluator: watches the req_ and rsp_ words,
// predicts each result and compares it field by field. Uses ale_pkg.
module associated_legendre_eval_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          bad_count,
   output int          ovf_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ale_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        bad_args;
      logic        overflow;
   } legendre_result_type;

   legendre_result_type expected_results[$];
   logic ovf_seen;

   // Magnitude-and-sign to signed, saturating.
   function automatic logic [63:0] pack_mag(input logic neg, input logic [63:0] mag);
      if (neg) begin
         if (mag > 64'h8000_0000_0000_0000) begin
            ovf_seen = 1'b1;
            return VAL_MIN;
         end
         return -mag;
      end
      if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
         ovf_seen = 1'b1;
         return VAL_MAX;
      end
      return mag;
   endfunction

   function automatic logic [63:0] abs64(input logic [63:0] a);
      return a[63] ? -a : a;
   endfunction

   // Product by a Q30 factor, rounded to nearest on the magnitude.
   function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] f);
      logic [63:0] ua, uf, prod;
      ua = abs64(a);
      uf = abs64(f);
      prod = (((ua >> 32) * uf) << 2) + (((ua & 64'hFFFF_FFFF) * uf + (64'd1 << 29)) >> 30);
      return pack_mag(a[63] != f[63], prod);
   endfunction

   // Product by a small positive integer, saturating.
   function automatic logic [63:0] int_product(input logic [63:0] a, input logic [63:0] k);
      logic [63:0] ua, lim;
      ua = abs64(a);
      lim = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (k != 0 && ua > lim / k) begin
         ovf_seen = 1'b1;
         return a[63] ? VAL_MIN : VAL_MAX;
      end
      return pack_mag(a[63], ua * k);
   endfunction

   function automatic logic [63:0] diff_sat(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (!a[63] && b[63] && r[63]) begin
         ovf_seen = 1'b1;
         return VAL_MAX;
      end
      if (a[63] && !b[63] && !r[63]) begin
         ovf_seen = 1'b1;
         return VAL_MIN;
      end
      return r;
   endfunction

   function automatic logic [63:0] quot_round(input logic [63:0] a, input logic [63:0] d);
      logic [63:0] ua, q, r;
      ua = abs64(a);
      q = ua / d;
      r = ua % d;
      if (r >= d - r) q++;
      return pack_mag(a[63], q);
   endfunction

   // Integer square root, rounded to nearest.
   function automatic logic [63:0] root_round(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 60;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (v > r) r++;
      return r;
   endfunction

   // Evaluates P_l^m(x) with the block's rounding and saturation.
   function automatic legendre_result_type legendre_eval(input logic [39:0] word);
      legendre_result_type res;
      logic [3:0] l, m;
      logic signed [63:0] x, root;
      logic [63:0] pmm, pnext, pll, t1, t2;
      int i, k;
      l = word[3:0];
      m = word[7:4];
      x = {{32{word[39]}}, word[39:8]};
      ovf_seen = 1'b0;
      pll = 0;
      if (m > l || l > MAX_DEGREE || x > 64'sd1073741824 || x < -64'sd1073741824) begin
         res.value = 0;
         res.bad_args = 1'b1;
         res.overflow = 1'b0;
         return res;
      end
      pmm = VAL_ONE;
      if (m > 0) begin
         root = root_round((64'd1 << 60) - x * x);
         for (i = 1; i <= m; i++) begin
            pmm = q30_product(pmm, root);
            pmm = int_product(pmm, 2 * i - 1);
            pmm = pack_mag(!pmm[63] && pmm != 0, abs64(pmm));
         end
      end
      if (l == m) begin
         pll = pmm;
      end else begin
         pnext = int_product(q30_product(pmm, x), 2 * m + 1);
         pll = pnext;
         for (k = m + 2; k <= l; k++) begin
            t1 = int_product(q30_product(pnext, x), 2 * k - 1);
            t2 = int_product(pmm, k + m - 1);
            pll = quot_round(diff_sat(t1, t2), k - m);
            pmm = pnext;
            pnext = pll;
         end
      end
      res.value = pll;
      res.bad_args = 1'b0;
      res.overflow = ovf_seen;
      return res;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on each accepted request word, compare on each accepted response word.
   always @(posedge clock) begin
      legendre_result_type want;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
         bad_count <= 0;
         ovf_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(legendre_eval(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            bad_count <= bad_count + rsp_tuser[0];
            ovf_count <= ovf_count + rsp_tuser[1];
            if (expected_results.size() == 0) begin
               $error("unexpected result word: value %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser[0] !== want.bad_args ||
                   rsp_tuser[1] !== want.overflow) fail_count <= fail_count + 1;
               if (rsp_tdata !== want.value)
                  $error("value: expected %h, actual %h", want.value, rsp_tdata);
               if (rsp_tuser[0] !== want.bad_args)
                  $error("bad_args: expected %b, actual %b", want.bad_args, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.overflow)
                  $error("overflow: expected %b, actual %b", want.overflow, rsp_tuser[1]);
            end
         end
      end
   end
endmodule

FILE: tb/associated_legendre_eval_core_test.sv
// Testbench top for the associated Legendre evaluator: clock, reset, stimulus
// and verdict. Uses ale_pkg, associated_legendre_eval_core and the checker.
module associated_legendre_eval_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ale_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int fail_count, pending_count, result_count, bad_count, ovf_count;
   int send_idle_pct, recv_stall_pct;
   int idle_cycles;

   associated_legendre_eval_core uut (.*);

   associated_legendre_eval_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stall at each falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_count);
         $display("*** FAILED ***");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Sends one request word after the sender's random idle gap. The valid stays
   // high on return so that words can follow back to back.
   task automatic send_word(input logic [3:0] l, input logic [3:0] m, input logic [31:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {x, m, l};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly legal arguments, with special values and some illegal ones.
   task automatic send_random;
      logic [3:0] l, m;
      logic [31:0] x;
      int pick;
      pick = $urandom_range(99);
      l = $urandom_range(MAX_DEGREE);
      m = $urandom_range(l);
      case ($urandom_range(9))
         0: x = X_PLUS_ONE;
         1: x = X_MINUS_ONE;
         2: x = 0;
         3: x = $urandom;
         default: x = $urandom_range(2147483647) % 32'd2147483649 - 32'd1073741824;
      endcase
      if (pick < 5) l = $urandom_range(15, MAX_DEGREE + 1);
      else if (pick < 10) m = $urandom_range(15);
      send_word(l, m, x);
   endtask

   initial begin
      int phase, n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, domain edges and each illegal-argument case.
      send_word(0, 0, 0);
      send_word(8, 8, 0);
      send_word(8, 0, X_PLUS_ONE);
      send_word(8, 0, X_MINUS_ONE);
      send_word(8, 4, X_PLUS_ONE);
      send_word(8, 8, X_MINUS_ONE);
      send_word(1, 0, 32'h2000_0000);
      send_word(2, 1, 32'hE000_0000);
      send_word(7, 3, 32'h0000_0001);
      send_word(8, 7, 32'hFFFF_FFFF);
      send_word(3, 4, 0);
      send_word(15, 15, 0);
      send_word(9, 0, 0);
      send_word(15, 0, 32'h1000_0000);
      send_word(4, 2, 32'h4000_0001);
      send_word(4, 2, 32'hBFFF_FFFF);
      send_word(0, 15, 32'h7FFF_FFFF);
      send_word(8, 3, 32'h8000_0000);
      send_word(5, 5, 32'h2AAA_AAAA);

      // Random phases with varying idling on either side.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            3: begin send_idle_pct = 15; recv_stall_pct = 15; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (n = 0; n < 300; n++) send_random();
         // Sender holds off until every result is back.
         req_tvalid <= 1'b0;
         do @(negedge clock); while (pending_count != 0);
      end

      repeat (700) @(negedge clock);
      $display("Covered %0d results: %0d with bad arguments, %0d saturated.",
               result_count, bad_count, ovf_count);
      $display("Idling phases: none, sender 65%%, receiver 65%%, both 15%%.");
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: associated_legendre_eval_core.f
rtl/core/ale_pkg.sv
rtl/core/ale_mul.sv
rtl/core/associated_legendre_eval_core.sv
tb/associated_legendre_eval_checker.sv
tb/associated_legendre_eval_core_test.sv
